// ----- design/array_linked_list_with_free_list_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the linked list block
// Shorthand for clocked concurrent checks on clk_i / rst_ni.
// ---------------------------------------------------------------------------
`ifndef ARRAY_LINKED_LIST_WITH_FREE_LIST_MACROS_SVH
`define ARRAY_LINKED_LIST_WITH_FREE_LIST_MACROS_SVH

// Check held off while reset is asserted.
`define ALFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds during reset.
`define ALFL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/alfl_pkg.sv -----
// ---------------------------------------------------------------------------
// alfl_pkg
// Operation and status codes and controller states for the list block.
// ---------------------------------------------------------------------------
package alfl_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP        = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TAKE = 5'b00010,
    ST_LINK = 5'b00100,
    ST_POP  = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  localparam int unsigned DATA_W = 32;

endpackage

// ----- design/alfl_ram.sv -----
// ---------------------------------------------------------------------------
// alfl_ram
// Single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module alfl_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/array_linked_list_with_free_list.sv -----
// Result: loaded into the result register from TAKE, POP or RESP after the input transfer
//   (from LINK for push at back onto a non-empty list); these wait while it is still full.
// Requests: one at a time; a new request is taken only in IDLE, once the previous
//   result has been loaded into the result register.
// Reset: head, tail and free list go to null, slot count to zero; node RAMs are
//   not cleared, as no entry is ever read before it is written.
// ---------------------------------------------------------------------------
// array_linked_list_with_free_list
// Singly linked list in a fixed node store, with a free list of popped nodes.
// ---------------------------------------------------------------------------
module array_linked_list_with_free_list
  import alfl_pkg::*;
#(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input request channel
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,  // [31:0] value_in
  input  logic [1:0]        s_axis_tuser_i,  // [1:0] operation
  // result channel
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o,  // [31:0] value_out
  output logic [1:0]        m_axis_tuser_o   // [1:0] status
);

`include "array_linked_list_with_free_list_macros.svh"

  // Index width holds every node index plus the null marker (CAPACITY).
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Only the low 32 stored bits can ever reach the result port.
  localparam int unsigned SW = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  // ---- control state ------------------------------------------------------
  state_e        state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [IW-1:0] free_q, free_d;
  logic [IW-1:0] slots_q, slots_d;

  // ---- request held while the node RAMs are worked on ---------------------
  op_e           op_q, op_d;
  logic [SW-1:0] val_q, val_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          from_free_q, from_free_d;
  status_e       resp_q, resp_d;

  // ---- output register ----------------------------------------------------
  logic              m_valid_q, m_valid_d;
  logic [DATA_W-1:0] m_data_q, m_data_d;
  status_e           m_user_q, m_user_d;

  // ---- RAM ports ----------------------------------------------------------
  logic          value_we, value_re;
  logic [AW-1:0] value_waddr, value_raddr;
  logic [SW-1:0] value_wdata, value_rdata;
  logic          link_we, link_re;
  logic [AW-1:0] link_waddr, link_raddr;
  logic [IW-1:0] link_wdata, link_rdata;

  logic              in_xfer;
  logic              out_free;
  logic              store_full;
  logic [DATA_W-1:0] pop_value;

  alfl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (SW),
    .AW    (AW)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (value_we),
    .waddr_i (value_waddr),
    .wdata_i (value_wdata),
    .re_i    (value_re),
    .raddr_i (value_raddr),
    .rdata_o (value_rdata)
  );

  alfl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (IW),
    .AW    (AW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  // One request at a time; a finished result may still sit in the output
  // register while the next request is taken.
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign store_full      = (free_q >= NIL) && (slots_q >= NIL);

  // sign-extend the popped value to the port width
  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      pop_value[i] = value_rdata[(i < SW) ? i : SW - 1];
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_d      = free_q;
    slots_d     = slots_q;
    op_d        = op_q;
    val_d       = val_q;
    idx_d       = idx_q;
    from_free_d = from_free_q;
    resp_d      = resp_q;

    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    value_we    = 1'b0;
    value_re    = 1'b0;
    value_waddr = idx_q[AW-1:0];
    value_wdata = val_q;
    value_raddr = head_q[AW-1:0];
    link_we     = 1'b0;
    link_re     = 1'b0;
    link_waddr  = idx_q[AW-1:0];
    link_wdata  = NIL;
    link_raddr  = head_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d  = op_e'(s_axis_tuser_i);
          val_d = s_axis_tdata_i[SW-1:0];
          case (s_axis_tuser_i)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (store_full) begin
                resp_d  = STATUS_FULL;
                state_d = ST_RESP;
              end else if (free_q < NIL) begin
                // reuse a freed node: its link names the next free one
                link_re     = 1'b1;
                link_raddr  = free_q[AW-1:0];
                idx_d       = free_q;
                from_free_d = 1'b1;
                state_d     = ST_TAKE;
              end else begin
                idx_d       = slots_q;
                from_free_d = 1'b0;
                state_d     = ST_TAKE;
              end
            end
            OP_POP: begin
              if (head_q >= NIL) begin
                resp_d  = STATUS_EMPTY;
                state_d = ST_RESP;
              end else begin
                value_re = 1'b1;
                link_re  = 1'b1;
                state_d  = ST_POP;
              end
            end
            default: begin
              // unused code: no effect
              resp_d  = STATUS_DONE;
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_TAKE: begin
        if (out_free) begin
          value_we   = 1'b1;
          link_we    = 1'b1;
          link_wdata = (op_q == OP_PUSH_FRONT) ? head_q : NIL;
          if (from_free_q) begin
            free_d = (link_rdata > NIL) ? NIL : link_rdata;
          end else begin
            slots_d = slots_q + IW'(1);
          end
          if (op_q == OP_PUSH_FRONT) begin
            head_d = idx_q;
            if (tail_q >= NIL) begin
              tail_d = idx_q;
            end
            m_valid_d = 1'b1;
            m_data_d  = '0;
            m_user_d  = STATUS_DONE;
            state_d   = ST_IDLE;
          end else if (head_q >= NIL) begin
            head_d    = idx_q;
            tail_d    = idx_q;
            m_valid_d = 1'b1;
            m_data_d  = '0;
            m_user_d  = STATUS_DONE;
            state_d   = ST_IDLE;
          end else begin
            // old tail still has to point at the new node
            state_d = ST_LINK;
          end
        end
      end

      ST_LINK: begin
        if (out_free) begin
          link_we    = 1'b1;
          link_waddr = tail_q[AW-1:0];
          link_wdata = idx_q;
          tail_d     = idx_q;
          m_valid_d  = 1'b1;
          m_data_d   = '0;
          m_user_d   = STATUS_DONE;
          state_d    = ST_IDLE;
        end
      end

      ST_POP: begin
        if (out_free) begin
          // popped node goes to the front of the free list
          link_we    = 1'b1;
          link_waddr = head_q[AW-1:0];
          link_wdata = free_q;
          free_d     = head_q;
          if (link_rdata >= NIL) begin
            head_d = NIL;
            tail_d = NIL;
          end else begin
            head_d = link_rdata;
          end
          m_valid_d = 1'b1;
          m_data_d  = pop_value;
          m_user_d  = STATUS_DONE;
          state_d   = ST_IDLE;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          m_user_d  = resp_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= NIL;
      tail_q    <= NIL;
      free_q    <= NIL;
      slots_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      free_q    <= free_d;
      slots_q   <= slots_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    val_q       <= val_d;
    idx_q       <= idx_d;
    from_free_q <= from_free_d;
    resp_q      <= resp_d;
    m_data_q    <= m_data_d;
    m_user_q    <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // ---- assertions -----------------------------------------------------------
  `ALFL_ASSERT(a_head_tail_null, (head_q == NIL) == (tail_q == NIL), "head/tail null mismatch")
  `ALFL_ASSERT_ALWAYS(a_no_write_idle, (state_q == ST_IDLE) |-> (!link_we && !value_we), "RAM written while idle")
  `ALFL_ASSERT(a_idle_hold, (state_q == ST_IDLE && !in_xfer) |=> (state_q == ST_IDLE), "left idle without transfer")
  `ALFL_ASSERT(a_index_range, (free_q <= NIL) && (slots_q <= NIL), "index beyond null marker")

endmodule

// ----- tb/array_linked_list_with_free_list_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// array_linked_list_with_free_list_test
// Drives push-front, push-back, pop and ignored requests into the list block
// and checks every result transfer against an in-bench model of the node
// store, the free list and the head and tail pointers. Both stream sides idle
// and stall at random. The receiver also holds off for a long stretch so that
// the block backs up.
// ---------------------------------------------------------------------------
module array_linked_list_with_free_list_test;
  import alfl_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam logic [4:0]  NULL_SLOT   = 5'd16;
  localparam logic [1:0]  OP_NONE     = 2'd3;   // undefined code, block ignores it
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } list_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  // shadow copy of the list state
  logic [31:0] node_value [SLOTS];
  logic [4:0]  node_link  [SLOTS];
  logic [4:0]  head_slot;
  logic [4:0]  tail_slot;
  logic [4:0]  free_slot;
  logic [4:0]  slots_taken;

  list_result_t pending_results [$];
  list_result_t oldest_result;
  int unsigned  fail_count  = 0;
  int unsigned  cycle_count = 0;

  // idling control
  bit          send_gaps_on  = 1'b1;
  logic        recv_gaps_on  = 1'b1;
  int unsigned hold_trigger  = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned recv_stall    = 0;

  array_linked_list_with_free_list uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),  // [31:0] value_in
    .s_axis_tuser_i  (s_tuser),  // [1:0] operation
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),  // [31:0] value_out
    .m_axis_tuser_o  (m_tuser)   // [1:0] status
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // phase 0 leans to pushes, 1 to pops, 2 is even
  function automatic logic [1:0] pick_op(input int unsigned phase);
    int unsigned r;
    int unsigned push_share;
    r = $urandom_range(0, 99);
    push_share = (phase == 0) ? 80 : (phase == 1) ? 25 : 48;
    if (r < 3) return OP_NONE;
    if (r < 3 + push_share) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    return OP_POP;
  endfunction

  // Applies one accepted request to the shadow list and queues its result.
  function automatic void apply_list_request(input logic [1:0] op, input logic [31:0] value);
    logic [4:0]   slot;
    list_result_t res;
    res.value  = '0;
    res.status = STATUS_DONE;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (free_slot >= NULL_SLOT && slots_taken >= NULL_SLOT) begin
          res.status = STATUS_FULL;
        end else begin
          if (free_slot < NULL_SLOT) begin
            slot      = free_slot;
            free_slot = node_link[slot];
            if (free_slot > NULL_SLOT) free_slot = NULL_SLOT;
          end else begin
            slot        = slots_taken;
            slots_taken = slots_taken + 5'd1;
          end
          node_value[slot] = value;
          if (op == OP_PUSH_FRONT) begin
            node_link[slot] = head_slot;
            head_slot       = slot;
            if (tail_slot >= NULL_SLOT) tail_slot = slot;
          end else begin
            node_link[slot] = NULL_SLOT;
            if (head_slot >= NULL_SLOT) head_slot = slot;
            else if (tail_slot < NULL_SLOT) node_link[tail_slot] = slot;
            tail_slot = slot;
          end
        end
      end
      OP_POP: begin
        if (head_slot >= NULL_SLOT) begin
          res.status = STATUS_EMPTY;
        end else begin
          slot      = head_slot;
          res.value = node_value[slot];
          head_slot = node_link[slot];
          if (head_slot >= NULL_SLOT) begin
            head_slot = NULL_SLOT;
            tail_slot = NULL_SLOT;
          end
          node_link[slot] = free_slot;
          free_slot       = slot;
        end
      end
      default: ;
    endcase
    pending_results.push_back(res);
  endfunction

  // Offers one request and returns at the edge it is taken, after any gap.
  task automatic send_request(input logic [1:0] op, input logic [31:0] value);
    int unsigned gap;
    s_valid <= 1'b1;
    s_tuser <= op;
    s_tdata <= value;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    apply_list_request(op, value);
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      s_tdata <= $urandom;
      s_tuser <= $urandom_range(0, 3);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Empty pop, ignored code, extremes, free-list reuse, then fill to full.
  task automatic test_directed();
    send_request(OP_POP, 32'h1234_5678);
    send_request(OP_NONE, 32'hdead_beef);
    send_request(OP_PUSH_BACK, 32'h7fff_ffff);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_POP, 32'h0);
    send_request(OP_POP, 32'hffff_ffff);
    send_request(OP_POP, 32'h0);
    for (int i = 0; i < SLOTS; i++) begin
      send_request(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                   (i == 0) ? 32'h0 : (i == 1) ? 32'hffff_ffff : $urandom);
    end
    send_request(OP_PUSH_FRONT, 32'h5555_5555);
    send_request(OP_PUSH_BACK, 32'haaaa_aaaa);
    send_request(OP_NONE, 32'hffff_ffff);
    send_request(OP_POP, 32'h0);
  endtask

  // Phases of fill, drain and even mix with random content.
  task automatic test_random_mix(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_request(pick_op((i / 64) % 3), pick_value());
    end
  endtask

  // Receiver holds off while the sender keeps offering, then the sender
  // pauses until the block has drained.
  task automatic test_backpressure(input int unsigned count);
    send_gaps_on = 1'b0;
    hold_trigger <= hold_trigger + 1;
    for (int unsigned i = 0; i < count; i++) begin
      send_request(pick_op(2), pick_value());
    end
    s_valid <= 1'b0;
    wait_for_results();
    send_gaps_on = 1'b1;
  endtask

  // Back-to-back stream with the receiver always ready.
  task automatic test_full_rate(input int unsigned count);
    send_gaps_on = 1'b0;
    recv_gaps_on <= 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      send_request(pick_op((i / 40) % 3), pick_value());
    end
    send_gaps_on = 1'b1;
    recv_gaps_on <= 1'b1;
  endtask

  // Receiver: long hold-off on request, otherwise random stalls.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        if (recv_gaps_on) recv_stall = pick_gap();
      end
    end
  end

  // Result checker: each transfer against the oldest pending result.
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: value_out %h status %0d", m_tdata, m_tuser);
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_tdata !== oldest_result.value || m_tuser !== oldest_result.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: value_out exp %h got %h, status exp %0d got %0d",
                     oldest_result.value, m_tdata, oldest_result.status, m_tuser);
        end
      end
    end
  end

  initial begin
    head_slot   = NULL_SLOT;
    tail_slot   = NULL_SLOT;
    free_slot   = NULL_SLOT;
    slots_taken = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(800);
    test_backpressure(60);
    test_full_rate(220);
    test_random_mix(750);

    s_valid <= 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- array_linked_list_with_free_list.f -----
+incdir+design
design/alfl_pkg.sv
design/alfl_ram.sv
design/array_linked_list_with_free_list.sv
tb/array_linked_list_with_free_list_test.sv
